FILE: design/gdt_pkg.sv
// Shared constants and control types for the glyph deduplication table.
`default_nettype none
package gdt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int HALF_W        = 64;
  localparam int GLYPH_W       = 2 * HALF_W;
  localparam int OUT_IDX_W     = 8;
  localparam int OUT_CNT_W     = 9;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } gdt_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } gdt_stat_t;

endpackage
`default_nettype wire

FILE: design/gdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/gdt_ctrl.sv
// Controller state machine that sequences accept, table scan and result.
`default_nettype none
module gdt_ctrl
  import gdt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire gdt_stat_t stat,
  output gdt_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  assign in_ready   = (state == ST_IDLE);
  assign cmd.load   = in_valid && (state == ST_IDLE);
  assign cmd.scan   = (state == ST_SCAN) && !stat.done;
  assign cmd.finish = (state == ST_FINISH) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/gdt_datapath.sv
// Datapath: glyph store, scan pointer, compare stage and result register.
`default_nettype none
module gdt_datapath
  import gdt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire gdt_cmd_t             cmd,
  output gdt_stat_t                 stat,
  input  wire logic                 start_of_frame,
  input  wire logic [HALF_W-1:0]    rows_low,
  input  wire logic [HALF_W-1:0]    rows_high,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OUT_IDX_W-1:0]      glyph_index,
  output logic                      newly_added,
  output logic                      overflow,
  output logic [OUT_CNT_W-1:0]      glyph_count
);

  logic [GLYPH_W-1:0] glyph;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               ovf;
  logic               ovf_next;
  logic [CNT_W-1:0]   scan_idx;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic [GLYPH_W-1:0] rdata;
  logic               issue;
  logic               hit;
  logic               full;
  logic               wr_en;
  logic [IDX_W-1:0]   res_idx;
  logic [IDX_W+OUT_IDX_W-1:0] idx_wide;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;

  assign issue = (scan_idx < count);
  assign hit   = rd_pend && (rdata == glyph);
  assign full  = (count == CNT_W'(TABLE_ENTRIES));
  assign wr_en = cmd.finish && !found && !full;

  assign stat.done     = found || (!issue && !rd_pend);
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    count_next = count;
    ovf_next   = ovf;
    res_idx    = '0;
    if (found) begin
      res_idx = found_idx;
    end else if (!full) begin
      res_idx    = count[IDX_W-1:0];
      count_next = count + CNT_W'(1);
    end else begin
      ovf_next = 1'b1;
    end
  end

  assign idx_wide = {{OUT_IDX_W{1'b0}}, res_idx};
  assign cnt_wide = {{OUT_CNT_W{1'b0}}, count_next};

  gdt_ram #(
    .WIDTH(GLYPH_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[IDX_W-1:0]),
    .wdata(glyph),
    .re   (cmd.scan && issue),
    .raddr(scan_idx[IDX_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph <= {rows_high, rows_low};
    end
    if (cmd.scan) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
    if (cmd.scan && hit && !found) begin
      found_idx <= rd_idx;
    end
    if (cmd.finish) begin
      glyph_index <= idx_wide[OUT_IDX_W-1:0];
      newly_added <= wr_en;
      overflow    <= ovf_next;
      glyph_count <= cnt_wide[OUT_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      scan_idx  <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        rd_pend  <= 1'b0;
        found    <= 1'b0;
        if (start_of_frame) begin
          count <= '0;
          ovf   <= 1'b0;
        end
      end else if (cmd.scan) begin
        rd_pend <= issue;
        if (issue) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (hit) begin
          found <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count     <= count_next;
        ovf       <= ovf_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/glyph_dedup_table.sv
// Top level of the glyph deduplication table.
// The search compares the input word with the glyphs stored when it starts (none after a
// start of frame) and stops at the first match; the table holds at most 256 glyphs.
// A new word is accepted only once the last result is in the output register, and the
// scan reads one stored glyph per cycle. Reset clears the glyph count and overflow flag,
// not the stored glyphs.
`default_nettype none
module glyph_dedup_table
  import gdt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 start_of_frame,
  input  wire logic [HALF_W-1:0]    rows_low,
  input  wire logic [HALF_W-1:0]    rows_high,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OUT_IDX_W-1:0]      glyph_index,
  output logic                      newly_added,
  output logic                      overflow,
  output logic [OUT_CNT_W-1:0]      glyph_count
);

  gdt_cmd_t  cmd;
  gdt_stat_t stat;

  gdt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  gdt_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .start_of_frame(start_of_frame),
    .rows_low      (rows_low),
    .rows_high     (rows_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .glyph_index   (glyph_index),
    .newly_added   (newly_added),
    .overflow      (overflow),
    .glyph_count   (glyph_count)
  );

endmodule
`default_nettype wire

FILE: design/gdt_checker.sv
// Port-level checker for the glyph deduplication table, bound to the top level.
`default_nettype none
module gdt_checker
  import gdt_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [OUT_IDX_W-1:0] glyph_index,
  input wire logic                 newly_added,
  input wire logic                 overflow,
  input wire logic [OUT_CNT_W-1:0] glyph_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(glyph_index) && $stable(glyph_count))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is being searched");

  a_added_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && newly_added |->
      glyph_count != '0 && (glyph_count - 9'd1) == {1'b0, glyph_index})
    else $error("new glyph not stored at the last index");

  a_added_no_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && newly_added |-> !overflow)
    else $error("glyph added while overflow is flagged");

endmodule

bind glyph_dedup_table gdt_checker u_gdt_checker (.*);
`default_nettype wire

FILE: test/tb_glyph_dedup_table.sv
// Self-checking testbench for the glyph deduplication table with a built-in lookup predictor.
`timescale 1ns / 1ps
module tb_glyph_dedup_table;
  import gdt_pkg::*;

  typedef struct packed {
    logic              start_of_frame;
    logic [HALF_W-1:0] rows_low;
    logic [HALF_W-1:0] rows_high;
  } glyph_word_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] glyph_index;
    logic                 newly_added;
    logic                 overflow;
    logic [OUT_CNT_W-1:0] glyph_count;
  } lookup_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 start_of_frame = 1'b0;
  logic [HALF_W-1:0]    rows_low = '0;
  logic [HALF_W-1:0]    rows_high = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_IDX_W-1:0] glyph_index;
  logic                 newly_added;
  logic                 overflow;
  logic [OUT_CNT_W-1:0] glyph_count;

  glyph_dedup_table dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_of_frame(start_of_frame),
    .rows_low(rows_low),
    .rows_high(rows_high),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .glyph_index(glyph_index),
    .newly_added(newly_added),
    .overflow(overflow),
    .glyph_count(glyph_count)
  );

  always #5 clk = ~clk;

  glyph_word_t    word_queue[$];
  lookup_result_t expected_lookups[$];
  glyph_word_t    next_word;
  lookup_result_t want;

  logic [HALF_W-1:0] stored_low[TABLE_ENTRIES];
  logic [HALF_W-1:0] stored_high[TABLE_ENTRIES];
  int                stored_count = 0;
  bit                overflow_flag = 1'b0;

  logic [HALF_W-1:0] pool_low[$];
  logic [HALF_W-1:0] pool_high[$];

  int total_words = 0;
  int words_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_armed = 1'b1;
  int hits = 0;
  int adds = 0;
  int overflow_misses = 0;
  int tables_filled = 0;
  int frames = 0;

  function automatic lookup_result_t lookup_glyph(input glyph_word_t w);
    lookup_result_t r;
    int slot;
    bit found;
    slot = 0;
    found = 1'b0;
    r.newly_added = 1'b0;
    if (w.start_of_frame) begin
      stored_count = 0;
      overflow_flag = 1'b0;
    end
    for (int i = 0; i < stored_count && !found; i++) begin
      if (stored_low[i] == w.rows_low && stored_high[i] == w.rows_high) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      hits++;
    end else if (stored_count < TABLE_ENTRIES) begin
      slot = stored_count;
      stored_low[slot] = w.rows_low;
      stored_high[slot] = w.rows_high;
      stored_count++;
      r.newly_added = 1'b1;
      adds++;
      if (stored_count == TABLE_ENTRIES) tables_filled++;
    end else begin
      slot = 0;
      overflow_flag = 1'b1;
      overflow_misses++;
    end
    r.glyph_index = OUT_IDX_W'(slot);
    r.overflow = overflow_flag;
    r.glyph_count = OUT_CNT_W'(stored_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input int got, input int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s is %0d, predicted %0d (result %0d)", field, got, exp_val,
                                results_seen));
  endtask

  function automatic logic [HALF_W-1:0] random_half();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_word(input bit sof, input logic [HALF_W-1:0] lo,
                            input logic [HALF_W-1:0] hi);
    glyph_word_t w;
    w.start_of_frame = sof;
    w.rows_low = lo;
    w.rows_high = hi;
    word_queue.push_back(w);
  endtask

  // A frame mixes fresh glyphs, repeats of glyphs already sent in the frame, and near
  // misses that differ from an earlier glyph in a single bit. Long frames carry no stray
  // start of frame, so they run the table full.
  task automatic queue_frame(input int length, input bit sof_first, input int repeat_pct);
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    bit sof;
    int pick;
    int flip;
    frames++;
    for (int k = 0; k < length; k++) begin
      sof = (k == 0 && sof_first) || (length < 100 && $urandom_range(99) == 0);
      if (sof) begin
        pool_low.delete();
        pool_high.delete();
      end
      if (pool_low.size() != 0 && $urandom_range(99) < repeat_pct) begin
        pick = $urandom_range(pool_low.size() - 1);
        lo = pool_low[pick];
        hi = pool_high[pick];
        if ($urandom_range(9) == 0) begin
          flip = $urandom_range(2 * HALF_W - 1);
          if (flip < HALF_W) lo[flip] = ~lo[flip];
          else hi[flip - HALF_W] = ~hi[flip - HALF_W];
          pool_low.push_back(lo);
          pool_high.push_back(hi);
        end
      end else begin
        lo = random_half();
        hi = random_half();
        if ($urandom_range(1) == 0) begin
          lo = lo & random_half() & random_half();
          hi = hi & random_half() & random_half();
        end
        pool_low.push_back(lo);
        pool_high.push_back(hi);
      end
      queue_word(sof, lo, hi);
    end
  endtask

  function automatic bit sender_idles();
    int phase;
    phase = words_accepted * 3 / total_words;
    case (phase)
      0: return $urandom_range(99) < 10;
      1: return $urandom_range(99) < 87;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    int phase;
    phase = results_seen * 3 / total_words;
    case (phase)
      0: return $urandom_range(99) < 87;
      1: return $urandom_range(99) < 10;
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_lookups.push_back(lookup_glyph({start_of_frame, rows_low, rows_high}));
        words_accepted <= words_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (word_queue.size() != 0 && !sender_idles()) begin
          next_word = word_queue.pop_front();
          in_valid <= 1'b1;
          start_of_frame <= next_word.start_of_frame;
          rows_low <= next_word.rows_low;
          rows_high <= next_word.rows_high;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("result word arrived with no lookup outstanding");
        end else begin
          want = expected_lookups.pop_front();
          check_field("glyph_index", int'(glyph_index), int'(want.glyph_index));
          check_field("newly_added", int'(newly_added), int'(want.newly_added));
          check_field("overflow", int'(overflow), int'(want.overflow));
          check_field("glyph_count", int'(glyph_count), int'(want.glyph_count));
        end
        results_seen <= results_seen + 1;
      end
      out_ready <= (hold_left == 0) && !receiver_idles();
    end
  end

  // One long receiver stall early on lets the output register and the search back up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && results_seen == 40) begin
      hold_left <= 3000;
      hold_armed <= 1'b0;
    end
  end

  initial begin
    queue_word(1'b0, '0, '0);
    queue_word(1'b0, '0, '0);
    queue_word(1'b0, '1, '1);
    queue_word(1'b0, '0, 64'd1);
    queue_word(1'b0, 64'd1, '0);
    queue_word(1'b0, '0, '0);
    queue_word(1'b0, 64'd1, '0);
    queue_word(1'b0, '0, 64'h8000_0000_0000_0000);
    queue_word(1'b0, 64'h8000_0000_0000_0000, '0);
    queue_word(1'b1, '1, '1);
    queue_word(1'b1, '1, '1);
    queue_word(1'b0, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    queue_word(1'b0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    queue_word(1'b0, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    queue_word(1'b0, '1, '1);
    queue_word(1'b1, '0, '1);
    queue_word(1'b0, '1, '0);
    queue_word(1'b0, '0, '1);
    while (word_queue.size() < 1400) begin
      if (frames == 1 || frames == 11) queue_frame(400, 1'b1, 25);
      else queue_frame($urandom_range(1, 40), $urandom_range(9) != 0, 40);
    end
    total_words = word_queue.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (words_accepted != total_words || expected_lookups.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Checked %0d lookups in %0d frames: %0d hits, %0d new entries.",
             results_seen, frames, hits, adds);
    $display("The table filled %0d times and %0d glyphs found no room.",
             tables_filled, overflow_misses);
    if (mismatches == 0) begin
      $display("tb_glyph_dedup_table passed");
    end else begin
      $display("tb_glyph_dedup_table failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Timeout with %0d of %0d words accepted and %0d results checked.",
             words_accepted, total_words, results_seen);
    $display("tb_glyph_dedup_table failed");
    $finish;
  end

endmodule

FILE: files.f
design/gdt_pkg.sv
design/gdt_ram.sv
design/gdt_ctrl.sv
design/gdt_datapath.sv
design/glyph_dedup_table.sv
design/gdt_checker.sv
test/tb_glyph_dedup_table.sv
